### hw/rtl/swrfc_pkg.sv
// ----------------------------------------------------------------------------
// swrfc_pkg
// shared types, constants and the crc-8 byte step for the reply frame checker
// ----------------------------------------------------------------------------
package swrfc_pkg;

    localparam int unsigned CfgIndexWidth = 4;
    localparam int unsigned CfgDataWidth  = 8;

    localparam logic [CfgIndexWidth-1:0] CFG_ECHO_COUNT    = 4'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_EXPECTED_REG  = 4'd1;

    localparam logic [5:0] ECHO_COUNT_RESET = 6'd4;
    localparam logic [5:0] COUNT_MAX        = 6'd63;

    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    // reply byte positions, relative to the end of the echo
    localparam logic [5:0] POS_SYNC     = 6'd0;
    localparam logic [5:0] POS_ADDR     = 6'd1;
    localparam logic [5:0] POS_REG      = 6'd2;
    localparam logic [5:0] POS_VALUE_LO = 6'd3;
    localparam logic [5:0] POS_VALUE_HI = 6'd6;
    localparam logic [5:0] POS_CRC      = 6'd7;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_SYNC = 3'd1,
        STATUS_BAD_ADDR = 3'd2,
        STATUS_BAD_REG  = 3'd3,
        STATUS_BAD_CRC  = 3'd4
    } status_t;

    // one byte of crc-8, data bits fed lsb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int j = 0; j < 8; j++)
        begin
            if (crc[7] ^ data[j])
            begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

### hw/rtl/single_wire_reply_frame_checker_core.sv
// ----------------------------------------------------------------------------
// single_wire_reply_frame_checker_core
// skips the echoed transmit bytes, then checks an eight-byte reply frame
// (sync, master address, register, four value bytes, crc-8) and returns status and value
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, rx_byte, frame_start  | in
//  result   | out_valid, out_stall, status, reply_value | out
//  config   | cfg_wr_en, cfg_index, cfg_data            | in
//
//  one byte per cycle while the result is not stalled: a request is captured
//  in an input register; when it advances, one pass of crc step and checks
//  updates the frame state and loads the result register.
//  reset clears the frame state and loads the register defaults.
//  a stalled result holds the pipe; the input register keeps taking requests
//  while it is empty or draining.
// ----------------------------------------------------------------------------
module single_wire_reply_frame_checker_core
    import swrfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               rx_byte,
    input  logic                     frame_start,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic [31:0]              reply_value,

    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic [5:0]  echo_count_reg;
    logic [7:0]  expected_reg_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;

    logic [5:0]  byte_count_reg,  byte_count_next;
    logic [7:0]  crc_reg,         crc_next;
    logic [31:0] value_acc_reg,   value_acc_next;
    status_t     first_error_reg, first_error_next;
    logic        frame_done_reg,  frame_done_next;

    logic        out_valid_reg,   out_valid_next;
    status_t     status_reg,      status_next;
    logic [31:0] reply_value_reg, reply_value_next;

    logic        advance;
    logic        in_accept;

    assign advance   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign reply_value = reply_value_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_count_reg   <= ECHO_COUNT_RESET;
            expected_reg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ECHO_COUNT:   echo_count_reg   <= cfg_data[5:0];
                CFG_EXPECTED_REG: expected_reg_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
    end

    // frame update
    always_comb
    begin
        logic [5:0]  count_cur;
        logic [7:0]  crc_cur;
        logic [31:0] value_cur;
        status_t     err_cur;
        logic        done_cur;
        logic [5:0]  rel;
        logic [1:0]  lane;

        count_cur = s1_start_reg ? 6'd0        : byte_count_reg;
        crc_cur   = s1_start_reg ? 8'd0        : crc_reg;
        value_cur = s1_start_reg ? 32'd0       : value_acc_reg;
        err_cur   = s1_start_reg ? STATUS_OK   : first_error_reg;
        done_cur  = s1_start_reg ? 1'b0        : frame_done_reg;

        rel  = count_cur - echo_count_reg;
        lane = 2'(rel - POS_VALUE_LO);

        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        value_acc_next   = value_acc_reg;
        first_error_next = first_error_reg;
        frame_done_next  = frame_done_reg;

        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        reply_value_next = reply_value_reg;

        if (advance)
        begin
            byte_count_next  = count_cur;
            crc_next         = crc_cur;
            value_acc_next   = value_cur;
            first_error_next = err_cur;
            frame_done_next  = done_cur;

            if (!done_cur)
            begin
                if (count_cur >= echo_count_reg)
                begin
                    if (rel < POS_CRC)
                    begin
                        crc_next = crc8_step(crc_cur, s1_byte_reg);
                    end
                    if (err_cur == STATUS_OK)
                    begin
                        if (rel == POS_SYNC && s1_byte_reg != SYNC_BYTE)
                        begin
                            first_error_next = STATUS_BAD_SYNC;
                        end
                        if (rel == POS_ADDR && s1_byte_reg != MASTER_ADDR)
                        begin
                            first_error_next = STATUS_BAD_ADDR;
                        end
                        if (rel == POS_REG && s1_byte_reg != expected_reg_reg)
                        begin
                            first_error_next = STATUS_BAD_REG;
                        end
                    end
                    if (rel >= POS_VALUE_LO && rel <= POS_VALUE_HI)
                    begin
                        value_acc_next = value_cur | (32'(s1_byte_reg) << {lane, 3'b000});
                    end
                    if (rel == POS_CRC)
                    begin
                        out_valid_next = 1'b1;
                        if (err_cur == STATUS_OK && s1_byte_reg != crc_cur)
                        begin
                            status_next = STATUS_BAD_CRC;
                        end
                        else
                        begin
                            status_next = err_cur;
                        end
                        // a failed frame reports a zero value
                        reply_value_next = (status_next == STATUS_OK) ? value_cur : 32'd0;
                        frame_done_next  = 1'b1;
                    end
                end

                if (count_cur >= COUNT_MAX)
                begin
                    frame_done_next = 1'b1;
                end
                else
                begin
                    byte_count_next = count_cur + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            crc_reg         <= '0;
            value_acc_reg   <= '0;
            first_error_reg <= STATUS_OK;
            frame_done_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
            value_acc_reg   <= value_acc_next;
            first_error_reg <= first_error_next;
            frame_done_reg  <= frame_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        reply_value_reg <= reply_value_next;
    end

endmodule
